// ----- rtl/assert_macros.svh -----
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define LMSR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LMSR_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LMSR_ASSERT(label, clk, rst, prop, msg)
`define LMSR_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ----- rtl/lmsr_pkg.sv -----
`timescale 1ns / 1ps

package lmsr_pkg;

  localparam int COLUMNS_DEF   = 96;
  localparam int LINES_DEF     = 64;
  localparam int SCAN_ROWS_DEF = 16;

  localparam int COL_W     = 7;
  localparam int LINE_W    = 6;
  localparam int ROW_SEL_W = 4;

  // stored active-low, so a dark byte is all ones
  localparam logic [7:0] DARK_BYTE = 8'hFF;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_SWAP  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  typedef struct packed {
    logic              colour;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic              lit;
  } item_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           red_bits;
    logic [7:0]           green_bits;
    logic [ROW_SEL_W-1:0] row_select;
    logic                 latch_last;
    logic                 pixel_lit;
    logic                 swap_pending;
  } result_t;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic swap_req;
    logic pix_read;
    logic pix_user;
    logic pix_write;
    logic answer;
    logic scan_start;
    logic scan_issue;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic scan_last;
  } dp_status_t;

endpackage

// ----- rtl/lmsr_ctrl.sv -----
`timescale 1ns / 1ps

module lmsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic [1:0]           func,
  input  lmsr_pkg::dp_status_t status,
  output logic                 s_tready,
  output lmsr_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WR_RD  = 3'd2;
  localparam logic [2:0] ST_WR_WB  = 3'd3;
  localparam logic [2:0] ST_RD_RD  = 3'd4;
  localparam logic [2:0] ST_RD_ANS = 3'd5;
  localparam logic [2:0] ST_SCAN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          case (func)
            lmsr_pkg::FUNC_WRITE: state_next = ST_WR_RD;
            lmsr_pkg::FUNC_READ:  state_next = ST_RD_RD;
            lmsr_pkg::FUNC_SWAP:  cmd.swap_req = 1'b1;
            lmsr_pkg::FUNC_TICK: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      // read-modify-write of one byte in the user half
      ST_WR_RD: begin
        cmd.pix_read = 1'b1;
        cmd.pix_user = 1'b1;
        state_next   = ST_WR_WB;
      end
      ST_WR_WB: begin
        cmd.pix_write = 1'b1;
        cmd.pix_user  = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_RD_RD: begin
        cmd.pix_read = 1'b1;
        state_next   = ST_RD_ANS;
      end
      ST_RD_ANS: begin
        if (status.out_free) begin
          cmd.answer = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.out_free) begin
          cmd.scan_issue = 1'b1;
          if (status.scan_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/lmsr_datapath.sv -----
`timescale 1ns / 1ps

module lmsr_datapath #(
  parameter int COLUMNS   = lmsr_pkg::COLUMNS_DEF,
  parameter int LINES     = lmsr_pkg::LINES_DEF,
  parameter int SCAN_ROWS = lmsr_pkg::SCAN_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lmsr_pkg::dp_cmd_t    cmd,
  input  lmsr_pkg::item_t      in_item,
  input  logic                 m_tready,
  output lmsr_pkg::dp_status_t status,
  output logic                 out_valid,
  output lmsr_pkg::result_t    result
);

  localparam int RowBytes   = COLUMNS / 8;
  localparam int PlaneDepth = 2 * LINES * RowBytes;
  localparam int AddrW      = $clog2(PlaneDepth);
  localparam int LnW        = $clog2(LINES);
  localparam int ByteW      = $clog2(RowBytes);
  localparam int RowW       = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int FirstLine  = LINES - SCAN_ROWS;

  // one memory per colour plane, both halves of the double buffer in each
  logic [7:0] red_mem   [PlaneDepth];
  logic [7:0] green_mem [PlaneDepth];

  lmsr_pkg::item_t item;
  logic [7:0]      pix_q;
  logic [7:0]      pix_new;
  logic [7:0]      pix_mask;
  logic [7:0]      scan_red;
  logic [7:0]      scan_green;
  logic [AddrW-1:0] clr_addr;
  logic [AddrW-1:0] pix_addr;
  logic [AddrW-1:0] scan_addr;
  logic [LnW-1:0]   cur;
  logic [ByteW-1:0] top;
  logic [ByteW-1:0] byte_idx;
  logic [RowW-1:0]  scan_row;
  logic             display_half;
  logic             swap_request;
  logic             in_range;
  logic             pix_half;
  logic             out_kind;
  logic             out_last;
  logic             out_lit;
  logic             out_swap;
  logic [lmsr_pkg::ROW_SEL_W-1:0] out_row;

  function automatic logic [AddrW-1:0] frame_addr(input logic half,
                                                  input logic [LnW-1:0] ln,
                                                  input logic [ByteW-1:0] b);
    frame_addr = AddrW'((int'(half) * LINES + int'(ln)) * RowBytes + int'(b));
  endfunction

  assign in_range  = (int'(item.col) < COLUMNS) && (int'(item.line) < LINES);
  assign pix_half  = cmd.pix_user ? ~display_half : display_half;
  assign pix_addr  = in_range ?
                     frame_addr(pix_half, LnW'(item.line), ByteW'(item.col >> 3)) : '0;
  assign scan_addr = frame_addr(display_half, cur, byte_idx);
  assign pix_mask  = 8'(8'd1 << item.col[2:0]);
  assign pix_new   = item.lit ? (pix_q & ~pix_mask) : (pix_q | pix_mask);

  assign status.clear_last = (clr_addr == AddrW'(PlaneDepth - 1));
  assign status.out_free   = !out_valid || m_tready;
  // last pair of a tick: the top byte of the group whose top byte is below four, on the tick's final line
  assign status.scan_last  = (int'(cur) < SCAN_ROWS) && (int'(top) < 4) &&
                             (byte_idx == top);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      red_mem[clr_addr]   <= lmsr_pkg::DARK_BYTE;
      green_mem[clr_addr] <= lmsr_pkg::DARK_BYTE;
    end else if (cmd.pix_write && in_range) begin
      if (item.colour) begin
        green_mem[pix_addr] <= pix_new;
      end else begin
        red_mem[pix_addr] <= pix_new;
      end
    end
    if (cmd.pix_read) begin
      pix_q <= item.colour ? green_mem[pix_addr] : red_mem[pix_addr];
    end
    // scan read data doubles as the output payload, held while stalled
    if (cmd.scan_issue) begin
      scan_red   <= red_mem[scan_addr];
      scan_green <= green_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
  end

  // byte walk: groups of four from the top of the line down, ascending inside
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cur      <= LnW'(FirstLine + int'(scan_row));
      top      <= ByteW'(RowBytes - 1);
      byte_idx <= ByteW'(RowBytes - 4);
    end else if (cmd.scan_issue) begin
      if (byte_idx != top) begin
        byte_idx <= byte_idx + ByteW'(1);
      end else if (int'(top) >= 4) begin
        top      <= top - ByteW'(4);
        byte_idx <= (int'(top) >= 7) ? top - ByteW'(7) : '0;
      end else begin
        cur      <= cur - LnW'(SCAN_ROWS);
        top      <= ByteW'(RowBytes - 1);
        byte_idx <= ByteW'(RowBytes - 4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      scan_row     <= '0;
      display_half <= 1'b0;
      swap_request <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (cmd.swap_req) begin
        swap_request <= 1'b1;
      end
      if (cmd.scan_issue && status.scan_last) begin
        if (scan_row == RowW'(SCAN_ROWS - 1)) begin
          scan_row <= '0;
          if (swap_request) begin
            display_half <= ~display_half;
            swap_request <= 1'b0;
          end
        end else begin
          scan_row <= scan_row + RowW'(1);
        end
      end
      if (cmd.scan_issue || cmd.answer) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      out_kind <= 1'b0;
      out_last <= status.scan_last;
      out_lit  <= 1'b0;
      out_row  <= lmsr_pkg::ROW_SEL_W'(scan_row);
      out_swap <= swap_request;
    end else if (cmd.answer) begin
      out_kind <= 1'b1;
      out_last <= 1'b0;
      out_lit  <= in_range & ~pix_q[item.col[2:0]];
      out_row  <= lmsr_pkg::ROW_SEL_W'(scan_row);
      out_swap <= swap_request;
    end
  end

  assign result.kind         = out_kind;
  assign result.red_bits     = out_kind ? 8'd0 : scan_red;
  assign result.green_bits   = out_kind ? 8'd0 : scan_green;
  assign result.row_select   = out_row;
  assign result.latch_last   = out_last;
  assign result.pixel_lit    = out_lit;
  assign result.swap_pending = out_swap;

endmodule

// ----- rtl/led_matrix_scan_refresh_core.sv -----
// Scan refresh for a two-colour COLUMNS x LINES LED matrix with 1/SCAN_ROWS
// multiplexing. Pixels live active-low in a double-buffered frame store:
// writes go to the user half, reads and scanning use the display half, and a
// requested swap takes effect when the scan row wraps. A scan tick produces
// (LINES/SCAN_ROWS)*(COLUMNS/8) red/green byte pairs (48 at the default
// size), the last one flagged on tlast for latching; they leave at one per
// cycle while the output is taken, bounded by the single scan read port of
// each colour plane. A pixel write steps through accept, read and write back,
// a pixel read through accept, read and answer, the answer waiting out any
// output stall, and a swap request is only accepted and noted. After reset a
// clearing pass fills both planes with dark, one address per cycle, over all
// 2*LINES*COLUMNS/8 addresses (1536 at the default size), during which no
// request is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_matrix_scan_refresh_core #(
  parameter int COLUMNS   = lmsr_pkg::COLUMNS_DEF,
  parameter int LINES     = lmsr_pkg::LINES_DEF,
  parameter int SCAN_ROWS = lmsr_pkg::SCAN_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // colour, col[6:0], line[5:0], lit, zero pad
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_bits, green_bits, row_select, pixel_lit,
                                 // swap_pending, zero pad
  output logic        m_tuser,   // kind
  output logic        m_tlast    // latch_last
);

  lmsr_pkg::dp_cmd_t    cmd;
  lmsr_pkg::dp_status_t status;
  lmsr_pkg::item_t      in_item;
  lmsr_pkg::result_t    result;

  assign in_item.colour = s_tdata[0];
  assign in_item.col    = s_tdata[7:1];
  assign in_item.line   = s_tdata[13:8];
  assign in_item.lit    = s_tdata[14];

  lmsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .func     (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  lmsr_datapath #(
    .COLUMNS   (COLUMNS),
    .LINES     (LINES),
    .SCAN_ROWS (SCAN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .m_tready  (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .result    (result)
  );

  assign m_tdata = {2'b00, result.swap_pending, result.pixel_lit, result.row_select,
                    result.green_bits, result.red_bits};
  assign m_tuser = result.kind;
  assign m_tlast = result.latch_last;

  `LMSR_ASSERT_NEVER(a_no_request_in_clear, clk, rst, cmd.clear_step && s_tready, "request taken during clearing pass")
  `LMSR_ASSERT(a_issue_has_room, clk, rst, (cmd.scan_issue || cmd.answer) |-> status.out_free, "result issued over a waiting result")
  `LMSR_ASSERT(a_last_frees_input, clk, rst, (cmd.scan_issue && status.scan_last) |=> s_tready, "input not ready after last chunk")
  `LMSR_ASSERT_NEVER(a_latch_on_chunk_only, clk, rst, m_tvalid && m_tlast && m_tuser, "latch flag on a read answer")

endmodule

// ----- sim/scan_refresh_checker.sv -----
`timescale 1ns / 1ps

module scan_refresh_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // colour, col[6:0], line[5:0], lit, zero pad
  input  logic [1:0]  s_tuser,   // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // red_bits, green_bits, row_select, pixel_lit,
                                 // swap_pending, zero pad
  input  logic        m_tuser,   // kind
  input  logic        m_tlast,   // latch_last
  output int          fail_count,
  output int          outstanding,
  output int          outputs_checked
);

  localparam int ROW_BYTES = lmsr_pkg::COLUMNS_DEF / 8;

  // 1 means dark, as in the block's own store
  bit      dark_px [2][2][lmsr_pkg::LINES_DEF][lmsr_pkg::COLUMNS_DEF];
  bit      shown_half;
  int      scan_pos;
  bit      swap_armed;
  lmsr_pkg::result_t matrix_out_q [$];

  function automatic logic [7:0] shown_byte(bit colour, int ln, int b);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) v[i] = dark_px[shown_half][colour][ln][b * 8 + i];
    return v;
  endfunction

  function automatic lmsr_pkg::result_t blank_result();
    lmsr_pkg::result_t r;
    r = '0;
    r.row_select = scan_pos[lmsr_pkg::ROW_SEL_W-1:0];
    r.swap_pending = swap_armed;
    return r;
  endfunction

  task automatic advance_matrix(logic [1:0] func, logic [15:0] d);
    bit      colour;
    int      col;
    int      ln;
    bit      lit;
    bit      in_range;
    lmsr_pkg::result_t r;
    int      n;
    colour = d[0];
    col = int'(d[7:1]);
    ln = int'(d[13:8]);
    lit = d[14];
    in_range = (col < lmsr_pkg::COLUMNS_DEF) && (ln < lmsr_pkg::LINES_DEF);
    n = 0;
    case (func)
      lmsr_pkg::FUNC_WRITE: begin
        // writes land in the half that is not shown
        if (in_range) dark_px[!shown_half][colour][ln][col] = !lit;
      end
      lmsr_pkg::FUNC_READ: begin
        r = blank_result();
        r.kind = 1'b1;
        r.pixel_lit = in_range && !dark_px[shown_half][colour][ln][col];
        matrix_out_q.push_back(r);
      end
      lmsr_pkg::FUNC_SWAP: begin
        swap_armed = 1'b1;
      end
      lmsr_pkg::FUNC_TICK: begin
        // lines from the bottom band up, byte groups from the top of the line down
        for (int cur = lmsr_pkg::LINES_DEF - lmsr_pkg::SCAN_ROWS_DEF + scan_pos; cur >= 0;
             cur -= lmsr_pkg::SCAN_ROWS_DEF)
          for (int top = ROW_BYTES - 1; top >= 0; top -= 4)
            for (int k = 3; k >= 0; k--)
              if (top - k >= 0) begin
                r = blank_result();
                r.red_bits = shown_byte(1'b0, cur, top - k);
                r.green_bits = shown_byte(1'b1, cur, top - k);
                matrix_out_q.push_back(r);
                n++;
              end
        if (n > 0) begin
          r = matrix_out_q.pop_back();
          r.latch_last = 1'b1;
          matrix_out_q.push_back(r);
        end
        scan_pos++;
        if (scan_pos >= lmsr_pkg::SCAN_ROWS_DEF) begin
          scan_pos = 0;
          if (swap_armed) begin
            shown_half = !shown_half;
            swap_armed = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lmsr_pkg::result_t want;
    if (rst) begin
      foreach (dark_px[h, c, l, x]) dark_px[h][c][l][x] = 1'b1;
      shown_half = 1'b0;
      scan_pos = 0;
      swap_armed = 1'b0;
      matrix_out_q.delete();
      fail_count = 0;
      outputs_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (matrix_out_q.size() == 0) begin
          $error("output with nothing expected: tdata %h, tuser %b, tlast %b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = matrix_out_q.pop_front();
          check_field("kind", int'(want.kind), int'(m_tuser));
          check_field("red_bits", int'(want.red_bits), int'(m_tdata[7:0]));
          check_field("green_bits", int'(want.green_bits), int'(m_tdata[15:8]));
          check_field("row_select", int'(want.row_select), int'(m_tdata[19:16]));
          check_field("latch_last", int'(want.latch_last), int'(m_tlast));
          check_field("pixel_lit", int'(want.pixel_lit), int'(m_tdata[20]));
          check_field("swap_pending", int'(want.swap_pending), int'(m_tdata[21]));
          outputs_checked++;
        end
      end
      if (s_tvalid && s_tready) advance_matrix(s_tuser, s_tdata);
    end
    outstanding = matrix_out_q.size();
  end

endmodule

// ----- sim/led_matrix_scan_refresh_core_tb.sv -----
`timescale 1ns / 1ps

module led_matrix_scan_refresh_core_tb;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 70;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = lmsr_pkg::FUNC_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_arm = 1'b0;
  int hold_left = 0;
  bit hold_taken = 1'b0;
  int quiet_cycles = 0;
  int sent_by_func [4] = '{0, 0, 0, 0};
  int fail_count;
  int outstanding;
  int outputs_checked;

  always #10 clk = ~clk;

  led_matrix_scan_refresh_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  scan_refresh_checker scoreboard (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .outputs_checked (outputs_checked)
  );

  // output side: random stalls, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_arm && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no handshake", QUIET_LIMIT);
      $display("led_matrix_scan_refresh_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pack_request(logic colour, logic [6:0] col,
                                               logic [5:0] ln, logic lit);
    return {1'b0, lit, ln, col, colour};
  endfunction

  // mostly on-panel columns, with some past the right edge
  function automatic logic [15:0] random_fields();
    logic [6:0] col;
    col = ($urandom_range(99) < 90) ? 7'($urandom_range(lmsr_pkg::COLUMNS_DEF - 1)) :
                                      7'($urandom_range(127, 96));
    return pack_request(1'($urandom_range(1)), col, 6'($urandom_range(63)),
                        1'($urandom_range(1)));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] func, logic [15:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent_by_func[func]++;
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) send_request(lmsr_pkg::FUNC_WRITE, random_fields());
    else if (pick < 65) send_request(lmsr_pkg::FUNC_READ, random_fields());
    else if (pick < 70) send_request(lmsr_pkg::FUNC_SWAP, random_fields());
    else send_request(lmsr_pkg::FUNC_TICK, random_fields());
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners, off-panel column, reads before and after a doubled swap request
    send_request(lmsr_pkg::FUNC_WRITE, pack_request(1'b0, 7'd0, 6'd0, 1'b1));
    send_request(lmsr_pkg::FUNC_WRITE, pack_request(1'b1, 7'd95, 6'd63, 1'b1));
    send_request(lmsr_pkg::FUNC_WRITE, pack_request(1'b0, 7'd127, 6'd5, 1'b1));
    send_request(lmsr_pkg::FUNC_READ, pack_request(1'b0, 7'd0, 6'd0, 1'b0));
    send_request(lmsr_pkg::FUNC_READ, pack_request(1'b1, 7'd100, 6'd10, 1'b1));
    send_request(lmsr_pkg::FUNC_SWAP, random_fields());
    send_request(lmsr_pkg::FUNC_SWAP, random_fields());
    repeat (lmsr_pkg::SCAN_ROWS_DEF) send_request(lmsr_pkg::FUNC_TICK, random_fields());
    send_request(lmsr_pkg::FUNC_READ, pack_request(1'b0, 7'd0, 6'd0, 1'b0));
    send_request(lmsr_pkg::FUNC_READ, pack_request(1'b1, 7'd95, 6'd63, 1'b0));
    send_request(lmsr_pkg::FUNC_READ, pack_request(1'b0, 7'd127, 6'd63, 1'b1));
    send_request(lmsr_pkg::FUNC_TICK, random_fields());
    send_request(lmsr_pkg::FUNC_WRITE, pack_request(1'b0, 7'd0, 6'd0, 1'b0));
    drain_outputs();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin
          idle_pct = 82;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 82;
        end
        3: begin
          idle_pct = 19;
          stall_pct <= 19;
        end
        4: begin
          // output held off while requests keep coming, so the input backs up
          idle_pct = 0;
          stall_pct <= 0;
          hold_arm <= 1'b1;
        end
        default: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
      drain_outputs();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d writes, %0d reads, %0d swap requests, %0d scan ticks",
             sent_by_func[lmsr_pkg::FUNC_WRITE], sent_by_func[lmsr_pkg::FUNC_READ],
             sent_by_func[lmsr_pkg::FUNC_SWAP], sent_by_func[lmsr_pkg::FUNC_TICK]);
    $display("compared %0d outputs over free-running, idle, stall and hold-off phases",
             outputs_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("led_matrix_scan_refresh_core_tb passed");
    end else begin
      $display("led_matrix_scan_refresh_core_tb failed");
    end
    $finish;
  end

endmodule
